// ===== hw/rtl/rrot_pkg.sv =====
// Shared widths, constants, types and helpers of the rotated rectangle overlap test.
`timescale 1ns / 1ps

package rrot_pkg;

  // CORDIC depth; steps beyond 32 are never run
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  localparam int COORD_W  = 32;   // Q16.16 centre
  localparam int DIM_W    = 31;   // Q15.16 full extent
  localparam int ANGIN_W  = 21;   // Q4.16 input angle
  localparam int ANG_W    = 22;   // angle or angle difference
  localparam int DIFF_W   = 33;   // centre offset
  localparam int BIG_W    = 36;   // angle in Q28 plus rounding offset
  localparam int Q_W      = 6;    // quadrant count
  localparam int Q_SPAN   = 21;   // quadrant thresholds on each side of zero
  localparam int Z_W      = 20;   // CORDIC residual angle, Q16
  localparam int CS_W     = 31;   // cos / sin, Q28
  localparam int KA_W     = 20;   // magnitude of the relative angle in 1e-4 rad
  localparam int N_W      = 36;
  localparam int TURN_MAX = 20;   // largest quarter-turn multiple that |k| can reach
  localparam int PH_W     = 48;   // half-offset by cos / sin products
  localparam int PW_W     = 63;   // extent by cos / sin products
  localparam int SUM_W    = 64;
  localparam int OFS_W    = 36;   // rotated centre offset, Q16
  localparam int GEO_W    = 38;   // geometry in Q.17
  localparam int AX_W     = 23;   // projection axis component, Q20
  localparam int PRJ_W    = 63;   // projection value

  localparam int SC_LAT    = CORDIC_RUN + 3;
  localparam int FR_LAT    = 3;
  localparam int SAT_LAT   = 4;
  localparam int TOTAL_LAT = 1 + SC_LAT + FR_LAT + SAT_LAT;

  localparam logic signed [BIG_W-1:0] HALF_PI_Q28  = 36'sd421657428;
  localparam logic signed [BIG_W-1:0] HALF_PI_HALF = 36'sd210828714;
  localparam logic signed [CS_W-1:0]  CORDIC_K_Q28 = 31'sd163008219;
  localparam logic [13:0]             RAD_SCALE    = 14'd10000;
  localparam int QUARTER_TURN_CODE = 15708;
  localparam int HALF_TURN_CODE    = 31416;

  localparam logic [1:0] QUAD_0   = 2'd0;
  localparam logic [1:0] QUAD_90  = 2'd1;
  localparam logic [1:0] QUAD_180 = 2'd2;
  localparam logic [1:0] QUAD_270 = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [DIM_W-1:0]          w1;
    logic [DIM_W-1:0]          h1;
    logic [DIM_W-1:0]          w2;
    logic [DIM_W-1:0]          h2;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic                      r1_nz;
    logic [KA_W-1:0]           ka;
  } side_t;

  typedef struct packed {
    logic [3:0][GEO_W-1:0] px;
    logic [3:0][GEO_W-1:0] py;
    logic [3:0][GEO_W-1:0] qx;
    logic [3:0][GEO_W-1:0] qy;
    logic signed [AX_W-1:0] ax_s;
    logic signed [AX_W-1:0] ax_c;
    logic                   aligned;
    logic                   aligned_hit;
  } geo_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] t;
    unique case (i)
      0:       t = 20'sd51472;
      1:       t = 20'sd30386;
      2:       t = 20'sd16055;
      3:       t = 20'sd8150;
      4:       t = 20'sd4091;
      5:       t = 20'sd2047;
      6:       t = 20'sd1024;
      7:       t = 20'sd512;
      8:       t = 20'sd256;
      9:       t = 20'sd128;
      10:      t = 20'sd64;
      11:      t = 20'sd32;
      12:      t = 20'sd16;
      13:      t = 20'sd8;
      14:      t = 20'sd4;
      15:      t = 20'sd2;
      16:      t = 20'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // closed intervals meet
  function automatic logic meet(input logic signed [PRJ_W-1:0] lo1,
                                input logic signed [PRJ_W-1:0] hi1,
                                input logic signed [PRJ_W-1:0] lo2,
                                input logic signed [PRJ_W-1:0] hi2);
    return !((hi1 < lo2) || (hi2 < lo1));
  endfunction

endpackage

// ===== hw/rtl/rrot_sincos.sv =====
// Pipelined sine / cosine: quadrant reduction followed by one CORDIC step per stage.
`timescale 1ns / 1ps

module rrot_sincos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic signed [rrot_pkg::ANG_W-1:0] angle,
  output logic                              out_vld,
  output logic signed [rrot_pkg::CS_W-1:0]  cos_q28,
  output logic signed [rrot_pkg::CS_W-1:0]  sin_q28
);

  localparam int N = rrot_pkg::CORDIC_RUN;

  logic signed [rrot_pkg::BIG_W-1:0] big;
  logic signed [rrot_pkg::BIG_W-1:0] vsh;
  logic [rrot_pkg::Q_SPAN-1:0]       ge_pos;
  logic [rrot_pkg::Q_SPAN-1:0]       lt_neg;
  logic signed [rrot_pkg::Q_W-1:0]   q_comb;

  logic signed [rrot_pkg::BIG_W-1:0] big_a;
  logic signed [rrot_pkg::Q_W-1:0]   q_a;
  logic                              vld_a;

  logic signed [rrot_pkg::BIG_W-1:0] res;
  logic signed [rrot_pkg::BIG_W-1:0] res_rnd;
  logic signed [rrot_pkg::Z_W-1:0]   z_b;
  logic [1:0]                        q_b;
  logic                              vld_b;

  logic signed [rrot_pkg::CS_W-1:0] x_in [N];
  logic signed [rrot_pkg::CS_W-1:0] y_in [N];
  logic signed [rrot_pkg::Z_W-1:0]  z_in [N];
  logic [1:0]                       q_in [N];
  logic                             v_in [N];
  logic signed [rrot_pkg::CS_W-1:0] x_s  [N];
  logic signed [rrot_pkg::CS_W-1:0] y_s  [N];
  logic signed [rrot_pkg::Z_W-1:0]  z_s  [N];
  logic [1:0]                       q_s  [N];
  logic                             v_s  [N];

  // quadrant count from independent threshold compares
  always_comb begin
    big = $signed({{(rrot_pkg::BIG_W-rrot_pkg::ANG_W){angle[rrot_pkg::ANG_W-1]}}, angle}) <<< 12;
    vsh = big + rrot_pkg::HALF_PI_HALF;
    for (int j = 0; j < rrot_pkg::Q_SPAN; j++) begin
      ge_pos[j] = (vsh >= rrot_pkg::HALF_PI_Q28 * (j + 1));
      lt_neg[j] = (vsh < -(rrot_pkg::HALF_PI_Q28 * j));
    end
    q_comb = rrot_pkg::Q_W'($countones(ge_pos)) - rrot_pkg::Q_W'($countones(lt_neg));
  end

  always_ff @(posedge clk) begin
    big_a <= big;
    q_a   <= q_comb;
  end

  always_comb begin
    res     = big_a - $signed({{(rrot_pkg::BIG_W-rrot_pkg::Q_W){q_a[rrot_pkg::Q_W-1]}}, q_a})
                      * rrot_pkg::HALF_PI_Q28;
    res_rnd = (res + 36'sd2048) >>> 12;
  end

  always_ff @(posedge clk) begin
    z_b <= res_rnd[rrot_pkg::Z_W-1:0];
    q_b <= q_a[1:0];
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        x_in[i] = rrot_pkg::CORDIC_K_Q28;
        y_in[i] = '0;
        z_in[i] = z_b;
        q_in[i] = q_b;
        v_in[i] = vld_b;
      end else begin
        x_in[i] = x_s[i-1];
        y_in[i] = y_s[i-1];
        z_in[i] = z_s[i-1];
        q_in[i] = q_s[i-1];
        v_in[i] = v_s[i-1];
      end
    end
  end

  // one micro-rotation per stage
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      q_s[i] <= q_in[i];
      if (z_in[i] >= 0) begin
        x_s[i] <= x_in[i] - (y_in[i] >>> i);
        y_s[i] <= y_in[i] + (x_in[i] >>> i);
        z_s[i] <= z_in[i] - rrot_pkg::atan_q16(i);
      end else begin
        x_s[i] <= x_in[i] + (y_in[i] >>> i);
        y_s[i] <= y_in[i] - (x_in[i] >>> i);
        z_s[i] <= z_in[i] + rrot_pkg::atan_q16(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      out_vld <= 1'b0;
      for (int i = 0; i < N; i++) begin
        v_s[i] <= 1'b0;
      end
    end else begin
      vld_a   <= in_vld;
      vld_b   <= vld_a;
      out_vld <= v_s[N-1];
      for (int i = 0; i < N; i++) begin
        v_s[i] <= v_in[i];
      end
    end
  end

  // fold the quadrant back in
  always_ff @(posedge clk) begin
    unique case (q_s[N-1])
      rrot_pkg::QUAD_0: begin
        cos_q28 <= x_s[N-1];
        sin_q28 <= y_s[N-1];
      end
      rrot_pkg::QUAD_90: begin
        cos_q28 <= -y_s[N-1];
        sin_q28 <= x_s[N-1];
      end
      rrot_pkg::QUAD_180: begin
        cos_q28 <= -x_s[N-1];
        sin_q28 <= -y_s[N-1];
      end
      default: begin
        cos_q28 <= y_s[N-1];
        sin_q28 <= -x_s[N-1];
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrot_frame.sv =====
// Frame change, rotated extents, corner build and the axis-aligned box test.
`timescale 1ns / 1ps

module rrot_frame (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  rrot_pkg::side_t                  side,
  input  logic signed [rrot_pkg::CS_W-1:0] c1,
  input  logic signed [rrot_pkg::CS_W-1:0] s1,
  input  logic signed [rrot_pkg::CS_W-1:0] c2,
  input  logic signed [rrot_pkg::CS_W-1:0] s2,
  output logic                             out_vld,
  output rrot_pkg::geo_t                   geo
);

  localparam int PH = rrot_pkg::PH_W;
  localparam int PW = rrot_pkg::PW_W;
  localparam int SW = rrot_pkg::SUM_W;
  localparam int GW = rrot_pkg::GEO_W;
  localparam int PJ = rrot_pkg::PRJ_W;

  // stage 1
  logic signed [16:0] dxh, dxl, dyh, dyl;
  logic signed [rrot_pkg::CS_W:0] s2e, c2e;
  logic signed [rrot_pkg::CS_W:0] s2r, c2r;
  logic al_c, sw_c;

  logic signed [PH-1:0] p_dxh_c, p_dxl_c, p_dyh_s, p_dyl_s;
  logic signed [PH-1:0] p_dyh_c, p_dyl_c, p_dxh_s, p_dxl_s;
  logic signed [PW-1:0] p_w2c, p_w2s, p_h2c, p_h2s;
  logic signed [rrot_pkg::AX_W-1:0] s20_1, c20_1;
  rrot_pkg::side_t side1;
  logic al1, sw1, vld1;

  // stage 2
  logic signed [SW-1:0] sum_x, sum_y, r_x, r_y, r_wc, r_ws, r_hc, r_hs;
  logic signed [rrot_pkg::OFS_W-1:0] rx2, ry2;
  logic signed [GW-1:0] hwc2, hws2, hhc2, hhs2;
  logic signed [rrot_pkg::AX_W-1:0] s20_2, c20_2;
  rrot_pkg::side_t side2;
  logic al2, sw2, vld2;

  // stage 3 combinational
  logic signed [GW-1:0] x1g, y1g, x2g, y2g, cx1, cy1, cx2, cy2;
  logic signed [GW-1:0] w1g, h1g, hw_g, hh_g;
  logic al_hit;

  always_comb begin
    dxh = $signed(side.dx[32:16]);
    dxl = $signed({1'b0, side.dx[15:0]});
    dyh = $signed(side.dy[32:16]);
    dyl = $signed({1'b0, side.dy[15:0]});
    s2e = $signed({s2[rrot_pkg::CS_W-1], s2});
    c2e = $signed({c2[rrot_pkg::CS_W-1], c2});
    s2r = (s2e + 32'sd128) >>> 8;
    c2r = (c2e + 32'sd128) >>> 8;
    al_c = 1'b0;
    sw_c = 1'b0;
    for (int j = 0; j <= rrot_pkg::TURN_MAX; j++) begin
      if (side.ka == rrot_pkg::KA_W'(j * rrot_pkg::QUARTER_TURN_CODE)) begin
        al_c = 1'b1;
        if (((j * rrot_pkg::QUARTER_TURN_CODE) % rrot_pkg::HALF_TURN_CODE) != 0) begin
          sw_c = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_dxh_c <= PH'(dxh) * PH'(c1);
    p_dxl_c <= PH'(dxl) * PH'(c1);
    p_dyh_s <= PH'(dyh) * PH'(s1);
    p_dyl_s <= PH'(dyl) * PH'(s1);
    p_dyh_c <= PH'(dyh) * PH'(c1);
    p_dyl_c <= PH'(dyl) * PH'(c1);
    p_dxh_s <= PH'(dxh) * PH'(s1);
    p_dxl_s <= PH'(dxl) * PH'(s1);
    p_w2c   <= PW'($signed({1'b0, side.w2})) * PW'(c2);
    p_w2s   <= PW'($signed({1'b0, side.w2})) * PW'(s2);
    p_h2c   <= PW'($signed({1'b0, side.h2})) * PW'(c2);
    p_h2s   <= PW'($signed({1'b0, side.h2})) * PW'(s2);
    s20_1   <= s2r[rrot_pkg::AX_W-1:0];
    c20_1   <= c2r[rrot_pkg::AX_W-1:0];
    side1   <= side;
    al1     <= al_c;
    sw1     <= sw_c;
  end

  // recombine partial products and round to Q16
  always_comb begin
    sum_x = ((SW'(p_dxh_c) + SW'(p_dyh_s)) <<< 16) + SW'(p_dxl_c) + SW'(p_dyl_s);
    sum_y = ((SW'(p_dyh_c) - SW'(p_dxh_s)) <<< 16) + SW'(p_dyl_c) - SW'(p_dxl_s);
    r_x   = (sum_x + (64'sd1 <<< 27)) >>> 28;
    r_y   = (sum_y + (64'sd1 <<< 27)) >>> 28;
    r_wc  = (SW'(p_w2c) + (64'sd1 <<< 27)) >>> 28;
    r_ws  = (SW'(p_w2s) + (64'sd1 <<< 27)) >>> 28;
    r_hc  = (SW'(p_h2c) + (64'sd1 <<< 27)) >>> 28;
    r_hs  = (SW'(p_h2s) + (64'sd1 <<< 27)) >>> 28;
  end

  always_ff @(posedge clk) begin
    rx2   <= r_x[rrot_pkg::OFS_W-1:0];
    ry2   <= r_y[rrot_pkg::OFS_W-1:0];
    hwc2  <= r_wc[GW-1:0];
    hws2  <= r_ws[GW-1:0];
    hhc2  <= r_hc[GW-1:0];
    hhs2  <= r_hs[GW-1:0];
    s20_2 <= s20_1;
    c20_2 <= c20_1;
    side2 <= side1;
    al2   <= al1;
    sw2   <= sw1;
  end

  // Q.17: centres doubled, half extents are the raw width codes
  always_comb begin
    x1g  = GW'(side2.x1);
    y1g  = GW'(side2.y1);
    if (side2.r1_nz) begin
      x2g = x1g + GW'(rx2);
      y2g = y1g + GW'(ry2);
    end else begin
      x2g = x1g + GW'(side2.dx);
      y2g = y1g + GW'(side2.dy);
    end
    cx1  = x1g <<< 1;
    cy1  = y1g <<< 1;
    cx2  = x2g <<< 1;
    cy2  = y2g <<< 1;
    w1g  = GW'(side2.w1);
    h1g  = GW'(side2.h1);
    hw_g = sw2 ? GW'(side2.h2) : GW'(side2.w2);
    hh_g = sw2 ? GW'(side2.w2) : GW'(side2.h2);
    al_hit = rrot_pkg::meet(PJ'(cx1 - w1g), PJ'(cx1 + w1g),
                            PJ'(cx2 - hw_g), PJ'(cx2 + hw_g)) &&
             rrot_pkg::meet(PJ'(cy1 - h1g), PJ'(cy1 + h1g),
                            PJ'(cy2 - hh_g), PJ'(cy2 + hh_g));
  end

  always_ff @(posedge clk) begin
    geo.px[0]       <= cx2 - hwc2 + hhs2;
    geo.py[0]       <= cy2 - hws2 - hhc2;
    geo.px[1]       <= cx2 + hwc2 + hhs2;
    geo.py[1]       <= cy2 + hws2 - hhc2;
    geo.px[2]       <= cx2 + hwc2 - hhs2;
    geo.py[2]       <= cy2 + hws2 + hhc2;
    geo.px[3]       <= cx2 - hwc2 - hhs2;
    geo.py[3]       <= cy2 - hws2 + hhc2;
    geo.qx[0]       <= cx1 - w1g;
    geo.qy[0]       <= cy1 - h1g;
    geo.qx[1]       <= cx1 + w1g;
    geo.qy[1]       <= cy1 - h1g;
    geo.qx[2]       <= cx1 + w1g;
    geo.qy[2]       <= cy1 + h1g;
    geo.qx[3]       <= cx1 - w1g;
    geo.qy[3]       <= cy1 + h1g;
    geo.ax_s        <= s20_2;
    geo.ax_c        <= c20_2;
    geo.aligned     <= al2;
    geo.aligned_hit <= al_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

endmodule

// ===== hw/rtl/rrot_sat.sv =====
// Separating-axis stages: bounding box check, corner projections, span compare, result register.
`timescale 1ns / 1ps

module rrot_sat (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  rrot_pkg::geo_t geo,
  output logic           done,
  output logic           overlap
);

  localparam int GW = rrot_pkg::GEO_W;
  localparam int PW = rrot_pkg::PRJ_W;

  logic signed [rrot_pkg::AX_W-1:0] ax_x [2];
  logic signed [rrot_pkg::AX_W-1:0] ax_y [2];
  logic signed [GW-1:0] cor_x [2][4];
  logic signed [GW-1:0] cor_y [2][4];
  logic signed [GW-1:0] bx0_c, bx1_c, by0_c, by1_c;

  // stage 1
  logic signed [PW-1:0] mp [2][2][4][2];
  logic signed [GW-1:0] bx0, bx1, by0, by1, qxl, qxh, qyl, qyh;
  logic al1, alh1, vld1;
  // stage 2
  logic signed [PW-1:0] pr [2][2][4];
  logic bb2, al2, alh2, vld2;
  // stage 3
  logic signed [PW-1:0] lo_c [2][2];
  logic signed [PW-1:0] hi_c [2][2];
  logic signed [PW-1:0] lo [2][2];
  logic signed [PW-1:0] hi [2][2];
  logic bb3, al3, alh3, vld3;
  logic hit;

  always_comb begin
    ax_x[0] = -geo.ax_s;
    ax_y[0] = geo.ax_c;
    ax_x[1] = geo.ax_c;
    ax_y[1] = geo.ax_s;
    for (int k = 0; k < 4; k++) begin
      cor_x[0][k] = $signed(geo.qx[k]);
      cor_y[0][k] = $signed(geo.qy[k]);
      cor_x[1][k] = $signed(geo.px[k]);
      cor_y[1][k] = $signed(geo.py[k]);
    end
    bx0_c = cor_x[1][0];
    bx1_c = cor_x[1][0];
    by0_c = cor_y[1][0];
    by1_c = cor_y[1][0];
    for (int k = 1; k < 4; k++) begin
      if (cor_x[1][k] < bx0_c) bx0_c = cor_x[1][k];
      if (cor_x[1][k] > bx1_c) bx1_c = cor_x[1][k];
      if (cor_y[1][k] < by0_c) by0_c = cor_y[1][k];
      if (cor_y[1][k] > by1_c) by1_c = cor_y[1][k];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      for (int r = 0; r < 2; r++) begin
        for (int k = 0; k < 4; k++) begin
          mp[a][r][k][0] <= PW'(cor_x[r][k]) * PW'(ax_x[a]);
          mp[a][r][k][1] <= PW'(cor_y[r][k]) * PW'(ax_y[a]);
        end
      end
    end
    bx0  <= bx0_c;
    bx1  <= bx1_c;
    by0  <= by0_c;
    by1  <= by1_c;
    qxl  <= cor_x[0][0];
    qxh  <= cor_x[0][1];
    qyl  <= cor_y[0][0];
    qyh  <= cor_y[0][2];
    al1  <= geo.aligned;
    alh1 <= geo.aligned_hit;
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      for (int r = 0; r < 2; r++) begin
        for (int k = 0; k < 4; k++) begin
          pr[a][r][k] <= mp[a][r][k][0] + mp[a][r][k][1];
        end
      end
    end
    bb2  <= rrot_pkg::meet(PW'(qxl), PW'(qxh), PW'(bx0), PW'(bx1)) &&
            rrot_pkg::meet(PW'(qyl), PW'(qyh), PW'(by0), PW'(by1));
    al2  <= al1;
    alh2 <= alh1;
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int r = 0; r < 2; r++) begin
        lo_c[a][r] = pr[a][r][0];
        hi_c[a][r] = pr[a][r][0];
        for (int k = 1; k < 4; k++) begin
          if (pr[a][r][k] < lo_c[a][r]) lo_c[a][r] = pr[a][r][k];
          if (pr[a][r][k] > hi_c[a][r]) hi_c[a][r] = pr[a][r][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lo   <= lo_c;
    hi   <= hi_c;
    bb3  <= bb2;
    al3  <= al2;
    alh3 <= alh2;
  end

  always_comb begin
    if (al3) begin
      hit = alh3;
    end else begin
      hit = bb3 &&
            rrot_pkg::meet(lo[0][0], hi[0][0], lo[0][1], hi[0][1]) &&
            rrot_pkg::meet(lo[1][0], hi[1][0], lo[1][1], hi[1][1]);
    end
  end

  always_ff @(posedge clk) begin
    overlap <= hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      done <= vld3;
    end
  end

endmodule

// ===== hw/rtl/rotated_rect_overlap_test_core.sv =====
// Top level of the rotated rectangle overlap test pipeline.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive the ten rectangle fields and raise start; a beat is
//   taken at every rising edge where start is high and busy is low. Busy is
//   high only while rst is high, so a new pair may enter on every cycle.
//   Result channel: done is high for exactly one cycle and overlap is valid
//   in that cycle. The receiver cannot hold results off; each beat is
//   delivered in the same order as the inputs.
//   Throughput: one pair per cycle. The depth is set by the CORDIC
//   pipeline, one micro-rotation per stage, both angles running side by
//   side in their own units, followed by three frame / corner stages and
//   four separating-axis stages.
//   Reset: synchronous rst clears every valid bit, so beats in flight are
//   dropped and no done is raised for them. Payload registers are not
//   cleared.
module rotated_rect_overlap_test_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rrot_pkg::COORD_W-1:0]  first_center_x,
  input  logic signed [rrot_pkg::COORD_W-1:0]  first_center_y,
  input  logic        [rrot_pkg::DIM_W-1:0]    first_width,
  input  logic        [rrot_pkg::DIM_W-1:0]    first_height,
  input  logic signed [rrot_pkg::ANGIN_W-1:0]  first_angle,
  input  logic signed [rrot_pkg::COORD_W-1:0]  second_center_x,
  input  logic signed [rrot_pkg::COORD_W-1:0]  second_center_y,
  input  logic        [rrot_pkg::DIM_W-1:0]    second_width,
  input  logic        [rrot_pkg::DIM_W-1:0]    second_height,
  input  logic signed [rrot_pkg::ANGIN_W-1:0]  second_angle,
  output logic                                 done,
  output logic                                 overlap
);

  localparam int LAT = rrot_pkg::SC_LAT;

  // input register stage
  logic                                in_vld;
  logic signed [rrot_pkg::COORD_W-1:0] in_x1, in_y1, in_x2, in_y2;
  logic        [rrot_pkg::DIM_W-1:0]   in_w1, in_h1, in_w2, in_h2;
  logic signed [rrot_pkg::ANGIN_W-1:0] in_r1, in_r2;

  logic signed [rrot_pkg::ANG_W-1:0] ang1, dang;
  logic        [rrot_pkg::ANG_W-1:0] dang_abs;
  logic        [rrot_pkg::N_W-1:0]   n_scaled;
  logic        [rrot_pkg::N_W-1:0]   k_rnd;
  rrot_pkg::side_t                   side_c;
  rrot_pkg::side_t                   side_d [LAT];

  logic                             sc_vld;
  logic signed [rrot_pkg::CS_W-1:0] c1, s1, c2, s2;
  logic                             fr_vld;
  rrot_pkg::geo_t                   geo;

  // busy only while reset holds the pipeline
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_x1 <= first_center_x;
      in_y1 <= first_center_y;
      in_w1 <= first_width;
      in_h1 <= first_height;
      in_r1 <= first_angle;
      in_x2 <= second_center_x;
      in_y2 <= second_center_y;
      in_w2 <= second_width;
      in_h2 <= second_height;
      in_r2 <= second_angle;
    end
  end

  // relative angle, its size in 1e-4 rad (halves away from zero), centre offsets
  always_comb begin
    ang1     = $signed({in_r1[rrot_pkg::ANGIN_W-1], in_r1});
    dang     = $signed({in_r2[rrot_pkg::ANGIN_W-1], in_r2}) - ang1;
    dang_abs = (dang < 0) ? rrot_pkg::ANG_W'(-dang) : rrot_pkg::ANG_W'(dang);
    n_scaled = rrot_pkg::N_W'(dang_abs) * rrot_pkg::N_W'(rrot_pkg::RAD_SCALE);
    k_rnd    = (n_scaled + rrot_pkg::N_W'(32768)) >> 16;

    side_c.x1    = in_x1;
    side_c.y1    = in_y1;
    side_c.w1    = in_w1;
    side_c.h1    = in_h1;
    side_c.w2    = in_w2;
    side_c.h2    = in_h2;
    side_c.dx    = rrot_pkg::DIFF_W'(in_x2) - rrot_pkg::DIFF_W'(in_x1);
    side_c.dy    = rrot_pkg::DIFF_W'(in_y2) - rrot_pkg::DIFF_W'(in_y1);
    side_c.r1_nz = (in_r1 != '0);
    side_c.ka    = k_rnd[rrot_pkg::KA_W-1:0];
  end

  // hold side data beside the CORDIC units
  always_ff @(posedge clk) begin
    for (int i = 0; i < LAT; i++) begin
      if (i == 0) begin
        side_d[i] <= side_c;
      end else begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  rrot_sincos u_sc_first (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .angle   (ang1),
    .out_vld (sc_vld),
    .cos_q28 (c1),
    .sin_q28 (s1)
  );

  rrot_sincos u_sc_rel (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .angle   (dang),
    .out_vld (),
    .cos_q28 (c2),
    .sin_q28 (s2)
  );

  rrot_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (sc_vld),
    .side    (side_d[LAT-1]),
    .c1      (c1),
    .s1      (s1),
    .c2      (c2),
    .s2      (s2),
    .out_vld (fr_vld),
    .geo     (geo)
  );

  rrot_sat u_sat (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (fr_vld),
    .geo     (geo),
    .done    (done),
    .overlap (overlap)
  );

endmodule

// ===== hw/rtl/rrot_checker.sv =====
// Port-level checker for the overlap test core, bound to the top level.
`timescale 1ns / 1ps

module rrot_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [rrot_pkg::COORD_W-1:0]  first_center_x,
  input logic signed [rrot_pkg::COORD_W-1:0]  first_center_y,
  input logic        [rrot_pkg::DIM_W-1:0]    first_width,
  input logic        [rrot_pkg::DIM_W-1:0]    first_height,
  input logic signed [rrot_pkg::ANGIN_W-1:0]  first_angle,
  input logic signed [rrot_pkg::COORD_W-1:0]  second_center_x,
  input logic signed [rrot_pkg::COORD_W-1:0]  second_center_y,
  input logic        [rrot_pkg::DIM_W-1:0]    second_width,
  input logic        [rrot_pkg::DIM_W-1:0]    second_height,
  input logic signed [rrot_pkg::ANGIN_W-1:0]  second_angle,
  input logic                                 done,
  input logic                                 overlap
);

  localparam int LAT = rrot_pkg::TOTAL_LAT;

  // every accepted beat yields its result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted beat produced no result");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without accepted beat");

  // a rectangle always overlaps itself
  a_self_overlap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy &&
     first_center_x == second_center_x && first_center_y == second_center_y &&
     first_width == second_width && first_height == second_height &&
     first_angle == second_angle) |-> ##LAT (done && overlap))
    else $error("identical rectangles reported apart");

endmodule

bind rotated_rect_overlap_test_core rrot_checker u_rrot_checker (.*);
